### rtl/core/mrpd_pkg.sv
// Shared types and character constants for the receive payload deframer.
`timescale 1ns / 1ps
`default_nettype none

package mrpd_pkg;

  // Header text "+CIPRCV:" and its length
  localparam int unsigned HDR_LEN_N = 8;
  localparam logic [3:0] HDR_LEN = 4'd8;

  typedef logic [7:0] hdr_text_t [0:HDR_LEN_N-1];

  localparam hdr_text_t HDR_TEXT = '{
    8'h2B, 8'h43, 8'h49, 8'h50, 8'h52, 8'h43, 8'h56, 8'h3A
  };

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Declared-length accumulator saturates here; always above any 16-bit limit
  localparam int unsigned ACCUM_W = 17;
  localparam logic [ACCUM_W-1:0] ACCUM_MAX = 17'h1FFFF;

  localparam logic [15:0] MAX_LEN_RESET = 16'd1460;

  // One result item plus its valid flag
  typedef struct packed {
    logic        valid;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic        last_byte;
    logic        frame_error;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/mrpd_engine.sv
// Per-byte header hunt, length parse and payload pass state machine.
`timescale 1ns / 1ps
`default_nettype none

module mrpd_engine #(
  parameter int unsigned LENGTH_WIDTH      = 16,
  parameter int unsigned MAX_LENGTH_DIGITS = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [15:0]   max_len_i,
  output mrpd_pkg::res_t     res_o
);
  import mrpd_pkg::*;

  localparam int unsigned DCW = $clog2(MAX_LENGTH_DIGITS + 1);
  localparam logic [DCW-1:0] DIGITS_MAX = DCW'(MAX_LENGTH_DIGITS);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic [3:0]              match_q, match_d;
  logic [ACCUM_W-1:0]      accum_q, accum_d;
  logic [DCW-1:0]          digits_q, digits_d;
  logic [LENGTH_WIDTH-1:0] left_q, left_d;
  logic [LENGTH_WIDTH-1:0] pos_q, pos_d;

  logic [3:0]         hunt_base;
  logic [3:0]         hunt_next;
  logic               hunt_done;
  logic               is_digit;
  logic [3:0]         digit_val;
  logic [20:0]        accum_mul;
  logic [ACCUM_W-1:0] accum_sat;
  logic [LENGTH_WIDTH-1:0] len_trunc;

  // Header matcher: restart from zero unless already hunting
  always_comb begin
    hunt_base = (phase_q == PH_HUNT && !match_q[3]) ? match_q : 4'd0;
    if (data_byte_i == HDR_TEXT[hunt_base[2:0]]) begin
      hunt_next = hunt_base + 4'd1;
    end else begin
      hunt_next = (data_byte_i == CH_PLUS) ? 4'd1 : 4'd0;
    end
    hunt_done = (hunt_next == HDR_LEN);
  end

  // Decimal accumulate: accum * 10 + digit, saturating
  always_comb begin
    is_digit  = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
    digit_val = 4'(data_byte_i - CH_ZERO);
    accum_mul = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1) + 21'(digit_val);
    accum_sat = (accum_mul > 21'(ACCUM_MAX)) ? ACCUM_MAX : accum_mul[ACCUM_W-1:0];
    len_trunc = LENGTH_WIDTH'(accum_q);
  end

  // Next state and result
  always_comb begin
    phase_d  = phase_q;
    match_d  = match_q;
    accum_d  = accum_q;
    digits_d = digits_q;
    left_d   = left_q;
    pos_d    = pos_q;
    res_o    = '0;

    case (phase_q)
      PH_LEN: begin
        if (is_digit) begin
          if (digits_q < DIGITS_MAX) begin
            accum_d  = accum_sat;
            digits_d = digits_q + DCW'(1);
          end else begin
            accum_d = ACCUM_MAX;
          end
        end else if (data_byte_i == CH_COMMA) begin
          // Drop the frame on empty or over-limit length
          phase_d  = PH_HUNT;
          match_d  = 4'd0;
          accum_d  = '0;
          digits_d = '0;
          if (digits_q != '0) begin
            if (accum_q > {1'b0, max_len_i}) begin
              res_o.valid       = 1'b1;
              res_o.frame_error = 1'b1;
            end else begin
              left_d = len_trunc;
              pos_d  = '0;
              if (len_trunc != '0) begin
                phase_d = PH_PAY;
              end
            end
          end
        end else begin
          accum_d  = '0;
          digits_d = '0;
          if (hunt_done) begin
            phase_d = PH_LEN;
            match_d = 4'd0;
          end else begin
            phase_d = PH_HUNT;
            match_d = hunt_next;
          end
        end
      end
      default: begin
        if (phase_q == PH_PAY && left_q != '0) begin
          // Pass one payload byte
          res_o.valid        = 1'b1;
          res_o.payload_byte = data_byte_i;
          res_o.byte_index   = 16'(pos_q);
          res_o.last_byte    = (left_q == LENGTH_WIDTH'(1));
          left_d = left_q - LENGTH_WIDTH'(1);
          pos_d  = pos_q + LENGTH_WIDTH'(1);
          if (left_q == LENGTH_WIDTH'(1)) begin
            phase_d  = PH_HUNT;
            match_d  = 4'd0;
            accum_d  = '0;
            digits_d = '0;
          end
        end else begin
          accum_d  = '0;
          digits_d = '0;
          if (hunt_done) begin
            phase_d = PH_LEN;
            match_d = 4'd0;
          end else begin
            phase_d = PH_HUNT;
            match_d = hunt_next;
          end
        end
      end
    endcase
  end

  // Hold state, advance on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      match_q  <= 4'd0;
      accum_q  <= '0;
      digits_q <= '0;
      left_q   <= '0;
      pos_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      match_q  <= match_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
    end
  end

`ifndef SYNTHESIS
  a_pay_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAY |-> left_q != '0)
    else $error("payload phase with no bytes left");

  a_match_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q < HDR_LEN)
    else $error("header match count out of range");

  a_digits_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= DIGITS_MAX)
    else $error("digit count above limit");

  a_idle_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(left_q) && $stable(pos_q))
    else $error("state changed without an item");
`endif

endmodule

`default_nettype wire

### rtl/core/modem_receive_payload_deframer_top.sv
// Top level of the receive payload deframer: input stage, engine, result stage.
// Each item waits in the input register; its result then enters the result register.
// Throughput: one byte per cycle unless out_stall_i holds back a result.
// A stalled result stays in the output register while one new item waits in
// the input register.
// Reset (rst_ni, async, active low) clears valid flags and engine state, sets max length to 1460.
`timescale 1ns / 1ps
`default_nettype none

module modem_receive_payload_deframer_top #(
  parameter int unsigned LENGTH_WIDTH      = 16,
  parameter int unsigned MAX_LENGTH_DIGITS = 5
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  payload_byte_o,
  output      logic [15:0] byte_index_o,
  output      logic        last_byte_o,
  output      logic        frame_error_o
);
  import mrpd_pkg::*;

  logic [15:0] max_len_q;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  res_t        out_res_q;
  res_t        eng_res;
  logic        advance;
  logic        step;
  logic        in_take;

  assign cfg_ready_o = 1'b1;

  // Result register frees when empty or taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
  end

  mrpd_engine #(
    .LENGTH_WIDTH      (LENGTH_WIDTH),
    .MAX_LENGTH_DIGITS (MAX_LENGTH_DIGITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .max_len_i   (max_len_q),
    .res_o       (eng_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && eng_res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step && eng_res.valid) begin
      out_res_q <= eng_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_res_q.payload_byte;
  assign byte_index_o   = out_res_q.byte_index;
  assign last_byte_o    = out_res_q.last_byte;
  assign frame_error_o  = out_res_q.frame_error;

`ifndef SYNTHESIS
  a_error_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_error_o |->
      payload_byte_o == 8'd0 && byte_index_o == 16'd0 && !last_byte_o)
    else $error("error result carries payload fields");

  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with nothing pending");

  a_no_step_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !step)
    else $error("item processed while result is stalled");
`endif

endmodule

`default_nettype wire
